>>> hw/rtl/linked_list_deque_manager_unit_assert.svh
// Assertion macros used by the deque manager port checker.
`ifndef LINKED_LIST_DEQUE_MANAGER_UNIT_ASSERT_SVH
`define LINKED_LIST_DEQUE_MANAGER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LLDQ_ASSERT_SAME(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LLDQ_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lldq_pkg.sv
// Types and constants of the linked list deque manager.
`default_nettype none

package lldq_pkg;

  localparam int NODES = 256;
  localparam int IDX_W = 8;
  localparam int PTR_W = 9;
  localparam int CNT_W = 9;

  // Null marker for head, tail and links
  localparam logic [PTR_W-1:0] NIL = PTR_W'(NODES);

  typedef enum logic [1:0] {
    FN_APPEND   = 2'd0,
    FN_PREPEND  = 2'd1,
    FN_POP_HEAD = 2'd2,
    FN_POP_TAIL = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPEND_LINK,
    ST_POP_HEAD,
    ST_WALK
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/lldq_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module lldq_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/linked_list_deque_manager_unit.sv
// Top level of the linked list deque manager.
//
// Keeps one singly linked list of node indices: head, tail and count live in
// registers, the next-pointer table in a 256 x 9 RAM with a registered read.
// An item is taken when start is high and busy is low; its result comes with
// a one-cycle done strobe that cannot be held off, and a new item may be
// started in the same cycle as that strobe. Prepend, and any pop that leaves
// the list with fewer than two nodes, strobe done in the cycle after they are
// taken. Append writes the new node's link, then in the append-link state the
// old tail's link. Pop head with two or more nodes left passes through the
// pop-head state for the RAM read of the head's link. Pop tail with two or
// more nodes left walks the links from the head, one RAM read per cycle, until
// it reaches the node before the tail or has made 256 hops.
`default_nettype none

module linked_list_deque_manager_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [1:0] func,
  input  wire logic [7:0] node_index,
  output logic            busy,
  output logic            done,
  output logic [7:0]      popped_node,
  output logic            popped_valid,
  output logic [8:0]      item_count
);

  localparam int PW = lldq_pkg::PTR_W;
  localparam int IW = lldq_pkg::IDX_W;

  lldq_pkg::state_t state, state_next;

  logic [PW-1:0] head, head_next;
  logic [PW-1:0] tail, tail_next;
  logic [PW-1:0] cnt, cnt_next;
  logic [PW-1:0] p, p_next;
  logic [PW-1:0] steps, steps_next;
  logic [IW-1:0] node, node_next;

  logic          done_next;
  logic [7:0]    popped_node_next;
  logic          popped_valid_next;
  logic [8:0]    item_count_next;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [PW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [PW-1:0] ram_rdata;

  logic [PW-1:0] link_val;
  logic [PW-1:0] cnt_inc;
  logic [PW-1:0] cnt_dec;
  logic [PW-1:0] cnt_pop;
  logic          list_empty;

  lldq_ram #(
    .WIDTH(lldq_pkg::PTR_W),
    .DEPTH(lldq_pkg::NODES)
  ) u_next_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy = (state != lldq_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lldq_pkg::ST_IDLE;
      head  <= lldq_pkg::NIL;
      tail  <= lldq_pkg::NIL;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
    p            <= p_next;
    steps        <= steps_next;
    node         <= node_next;
    popped_node  <= popped_node_next;
    popped_valid <= popped_valid_next;
    item_count   <= item_count_next;
  end

  always_comb begin
    // The link of the null marker is the null marker itself
    link_val   = (p >= lldq_pkg::NIL) ? lldq_pkg::NIL : ram_rdata;
    cnt_inc    = (cnt < lldq_pkg::NIL) ? cnt + PW'(1) : cnt;
    cnt_dec    = (cnt != '0) ? cnt - PW'(1) : cnt;
    list_empty = (head == lldq_pkg::NIL) && (tail == lldq_pkg::NIL);
    cnt_pop    = cnt;

    state_next        = state;
    head_next         = head;
    tail_next         = tail;
    cnt_next          = cnt;
    p_next            = p;
    steps_next        = steps;
    node_next         = node;
    done_next         = 1'b0;
    popped_node_next  = popped_node;
    popped_valid_next = popped_valid;
    item_count_next   = item_count;
    ram_we            = 1'b0;
    ram_waddr         = node_index;
    ram_wdata         = lldq_pkg::NIL;
    ram_raddr         = head[IW-1:0];

    unique case (state)
      lldq_pkg::ST_IDLE: begin
        if (start) begin
          node_next = node_index;
          unique case (lldq_pkg::func_t'(func))
            lldq_pkg::FN_APPEND: begin
              // Terminate the new node now, link the old tail next cycle
              ram_we            = 1'b1;
              ram_waddr         = node_index;
              ram_wdata         = lldq_pkg::NIL;
              cnt_next          = cnt_inc;
              popped_node_next  = '0;
              popped_valid_next = 1'b0;
              item_count_next   = cnt_inc;
              state_next        = lldq_pkg::ST_APPEND_LINK;
            end
            lldq_pkg::FN_PREPEND: begin
              ram_we    = 1'b1;
              ram_waddr = node_index;
              ram_wdata = list_empty ? lldq_pkg::NIL : head;
              head_next = PW'(node_index);
              if (list_empty) begin
                tail_next = PW'(node_index);
              end
              cnt_next          = cnt_inc;
              popped_node_next  = '0;
              popped_valid_next = 1'b0;
              item_count_next   = cnt_inc;
              done_next         = 1'b1;
            end
            lldq_pkg::FN_POP_HEAD: begin
              if (head != lldq_pkg::NIL) begin
                cnt_pop = cnt_dec;
              end
              cnt_next          = cnt_pop;
              popped_valid_next = (head != lldq_pkg::NIL);
              popped_node_next  = (head != lldq_pkg::NIL) ? head[IW-1:0] : '0;
              item_count_next   = cnt_pop;
              if (cnt_pop == '0) begin
                head_next = lldq_pkg::NIL;
                tail_next = lldq_pkg::NIL;
                done_next = 1'b1;
              end else if (cnt_pop == PW'(1)) begin
                head_next = tail;
                done_next = 1'b1;
              end else begin
                p_next     = head;
                ram_raddr  = head[IW-1:0];
                state_next = lldq_pkg::ST_POP_HEAD;
              end
            end
            lldq_pkg::FN_POP_TAIL: begin
              if (tail != lldq_pkg::NIL) begin
                cnt_pop = cnt_dec;
              end
              cnt_next          = cnt_pop;
              popped_valid_next = (tail != lldq_pkg::NIL);
              popped_node_next  = (tail != lldq_pkg::NIL) ? tail[IW-1:0] : '0;
              item_count_next   = cnt_pop;
              if (cnt_pop == '0) begin
                head_next = lldq_pkg::NIL;
                tail_next = lldq_pkg::NIL;
                done_next = 1'b1;
              end else if (cnt_pop == PW'(1)) begin
                tail_next = head;
                ram_we    = (head < lldq_pkg::NIL);
                ram_waddr = head[IW-1:0];
                ram_wdata = lldq_pkg::NIL;
                done_next = 1'b1;
              end else begin
                // Start the walk at the head
                p_next     = head;
                steps_next = '0;
                ram_raddr  = head[IW-1:0];
                state_next = lldq_pkg::ST_WALK;
              end
            end
            default: begin
              state_next = lldq_pkg::ST_IDLE;
            end
          endcase
        end
      end

      lldq_pkg::ST_APPEND_LINK: begin
        if (list_empty) begin
          head_next = PW'(node);
          tail_next = PW'(node);
        end else begin
          ram_we    = (tail < lldq_pkg::NIL);
          ram_waddr = tail[IW-1:0];
          ram_wdata = PW'(node);
          tail_next = PW'(node);
        end
        done_next  = 1'b1;
        state_next = lldq_pkg::ST_IDLE;
      end

      lldq_pkg::ST_POP_HEAD: begin
        head_next  = link_val;
        done_next  = 1'b1;
        state_next = lldq_pkg::ST_IDLE;
      end

      lldq_pkg::ST_WALK: begin
        if ((link_val != tail) && (steps < PW'(lldq_pkg::NODES))) begin
          // Advance one hop and fetch its link for the next cycle
          p_next     = link_val;
          steps_next = steps + PW'(1);
          ram_raddr  = link_val[IW-1:0];
        end else begin
          ram_we     = (p < lldq_pkg::NIL);
          ram_waddr  = p[IW-1:0];
          ram_wdata  = lldq_pkg::NIL;
          tail_next  = p;
          done_next  = 1'b1;
          state_next = lldq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = lldq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/lldq_checker.sv
// Port-level checker for the linked list deque manager, bound to the top level.
`default_nettype none

`include "linked_list_deque_manager_unit_assert.svh"

module lldq_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic [1:0] func,
  input wire logic [7:0] node_index,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [7:0] popped_node,
  input wire logic       popped_valid,
  input wire logic [8:0] item_count
);

  logic unused_in;
  assign unused_in = ^{func, node_index};

  `LLDQ_ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "result strobed while busy")
  `LLDQ_ASSERT_SAME(a_empty_pop_zero, clk, rst, done && !popped_valid, popped_node == 8'd0, "node nonzero without valid")
  `LLDQ_ASSERT_SAME(a_count_range, clk, rst, done, item_count <= 9'(lldq_pkg::NODES), "count above node total")
  `LLDQ_ASSERT_NEXT(a_accept_moves, clk, rst, start && !busy, busy || done, "accepted item neither busy nor done")
  `LLDQ_ASSERT_SAME(a_busy_end_done, clk, rst, $fell(busy), done, "busy dropped without a result")

endmodule

bind linked_list_deque_manager_unit lldq_checker u_lldq_checker (.*);

`default_nettype wire

>>> bench/linked_list_deque_manager_checker.sv
// Checker for the deque manager: predicts every result and compares it with the block.
`timescale 1ns / 1ps

module linked_list_deque_manager_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       busy,
  input  wire logic [1:0] func,
  input  wire logic [7:0] node_index,
  input  wire logic       done,
  input  wire logic [7:0] popped_node,
  input  wire logic       popped_valid,
  input  wire logic [8:0] item_count,
  output int              fail_count,
  output int              outstanding
);

  typedef struct {
    logic [7:0]                 node;
    logic                       valid;
    logic [lldq_pkg::CNT_W-1:0] count;
  } deque_result_t;

  logic [lldq_pkg::PTR_W-1:0] head_q;
  logic [lldq_pkg::PTR_W-1:0] tail_q;
  logic [lldq_pkg::CNT_W-1:0] count_q;
  logic [lldq_pkg::PTR_W-1:0] links [lldq_pkg::NODES];

  deque_result_t pending_results [$];

  // The null marker links to itself and cannot be written.
  function automatic logic [lldq_pkg::PTR_W-1:0] link_at(
    input logic [lldq_pkg::PTR_W-1:0] p
  );
    if (p >= lldq_pkg::NIL) return lldq_pkg::NIL;
    return links[p[lldq_pkg::IDX_W-1:0]];
  endfunction

  function automatic void write_link(
    input logic [lldq_pkg::PTR_W-1:0] p,
    input logic [lldq_pkg::PTR_W-1:0] v
  );
    if (p < lldq_pkg::NIL) links[p[lldq_pkg::IDX_W-1:0]] = v;
  endfunction

  function automatic deque_result_t apply_op(input lldq_pkg::func_t f, input logic [7:0] n);
    deque_result_t r;
    logic [lldq_pkg::PTR_W-1:0] node;
    logic [lldq_pkg::PTR_W-1:0] victim;
    logic [lldq_pkg::PTR_W-1:0] p;
    int steps;
    node = {1'b0, n};
    r.node = '0;
    r.valid = 1'b0;
    case (f) inside
      lldq_pkg::FN_APPEND, lldq_pkg::FN_PREPEND: begin
        write_link(node, lldq_pkg::NIL);
        if (head_q == lldq_pkg::NIL && tail_q == lldq_pkg::NIL) begin
          head_q = node;
          tail_q = node;
        end else if (f == lldq_pkg::FN_APPEND) begin
          write_link(tail_q, node);
          tail_q = node;
        end else begin
          write_link(node, head_q);
          head_q = node;
        end
        if (count_q < lldq_pkg::NIL) count_q = count_q + 1'b1;
      end
      lldq_pkg::FN_POP_HEAD: begin
        victim = head_q;
        if (victim != lldq_pkg::NIL) begin
          r.valid = 1'b1;
          r.node = victim[lldq_pkg::IDX_W-1:0];
          if (count_q > 0) count_q = count_q - 1'b1;
        end
        if (count_q == 0) begin
          head_q = lldq_pkg::NIL;
          tail_q = lldq_pkg::NIL;
        end else if (count_q == 1) begin
          head_q = tail_q;
        end else begin
          head_q = link_at(victim);
        end
      end
      default: begin
        victim = tail_q;
        if (victim != lldq_pkg::NIL) begin
          r.valid = 1'b1;
          r.node = victim[lldq_pkg::IDX_W-1:0];
          if (count_q > 0) count_q = count_q - 1'b1;
        end
        if (count_q == 0) begin
          head_q = lldq_pkg::NIL;
          tail_q = lldq_pkg::NIL;
        end else if (count_q == 1) begin
          tail_q = head_q;
          write_link(head_q, lldq_pkg::NIL);
        end else begin
          // walk to the node before the tail, giving up after NODES hops
          p = head_q;
          steps = 0;
          while (link_at(p) != victim && steps < lldq_pkg::NODES) begin
            p = link_at(p);
            steps++;
          end
          write_link(p, lldq_pkg::NIL);
          tail_q = p;
        end
      end
    endcase
    r.count = count_q;
    return r;
  endfunction

  always @(posedge clk) begin
    deque_result_t want;
    if (rst) begin
      head_q = lldq_pkg::NIL;
      tail_q = lldq_pkg::NIL;
      count_q = '0;
      pending_results.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      // compare first: a new item may start in the cycle of the strobe
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result with none expected: popped_node %0d popped_valid %0d item_count %0d",
                 popped_node, popped_valid, item_count);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (popped_node !== want.node) begin
            $error("popped_node: expected %0d, got %0d", want.node, popped_node);
            fail_count++;
          end
          if (popped_valid !== want.valid) begin
            $error("popped_valid: expected %0d, got %0d", want.valid, popped_valid);
            fail_count++;
          end
          if (item_count !== want.count) begin
            $error("item_count: expected %0d, got %0d", want.count, item_count);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        pending_results.push_back(apply_op(lldq_pkg::func_t'(func), node_index));
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

>>> bench/linked_list_deque_manager_unit_test.sv
// Testbench top for the deque manager: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module linked_list_deque_manager_unit_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 300;

  logic       clk;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] func = lldq_pkg::FN_APPEND;
  logic [7:0] node_index = '0;
  logic       busy;
  logic       done;
  logic [7:0] popped_node;
  logic       popped_valid;
  logic [8:0] item_count;

  int fail_count;
  int outstanding;
  int idle_cycles = 0;

  // stimulus-side copy of the list, valid while no listed node is reinserted
  logic [7:0] shadow [$];
  bit         member [lldq_pkg::NODES];
  int         items_sent = 0;
  int         ops_seen [4];
  int         max_fill = 0;
  bit         no_gaps = 1'b0;

  linked_list_deque_manager_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .func(func),
    .node_index(node_index),
    .busy(busy),
    .done(done),
    .popped_node(popped_node),
    .popped_valid(popped_valid),
    .item_count(item_count)
  );

  linked_list_deque_manager_checker u_checker (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .node_index(node_index),
    .done(done),
    .popped_node(popped_node),
    .popped_valid(popped_valid),
    .item_count(item_count),
    .fail_count(fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold start high until the item is taken; leave it high for a back-to-back item.
  task automatic issue(input lldq_pkg::func_t f, input logic [7:0] n);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    node_index <= n;
    do @(posedge clk); while (busy);
    items_sent++;
    ops_seen[f]++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] free_node();
    int k;
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    for (k = 0; k < lldq_pkg::NODES; k++) begin
      if (!member[c]) return c;
      c = c + 8'd1;
    end
    return c;
  endfunction

  task automatic insert_fresh();
    logic [7:0] n;
    lldq_pkg::func_t f;
    n = free_node();
    f = $urandom_range(0, 1) ? lldq_pkg::FN_PREPEND : lldq_pkg::FN_APPEND;
    if (f == lldq_pkg::FN_APPEND) shadow.push_back(n);
    else shadow.push_front(n);
    member[n] = 1'b1;
    if (shadow.size() > max_fill) max_fill = shadow.size();
    issue(f, n);
  endtask

  task automatic pop_some(input int head_pct);
    lldq_pkg::func_t f;
    logic [7:0] n;
    f = ($urandom_range(0, 99) < head_pct) ? lldq_pkg::FN_POP_HEAD : lldq_pkg::FN_POP_TAIL;
    if (shadow.size() > 0) begin
      if (f == lldq_pkg::FN_POP_HEAD) n = shadow.pop_front();
      else n = shadow.pop_back();
      member[n] = 1'b0;
    end
    // node_index is don't-care for pops; toggle it anyway
    issue(f, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int target;
    int len;
    int k;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // pops on an empty list, then inserts at the index extremes
    issue(lldq_pkg::FN_POP_HEAD, 8'd0);
    issue(lldq_pkg::FN_POP_TAIL, 8'd255);
    issue(lldq_pkg::FN_APPEND, 8'd0);
    issue(lldq_pkg::FN_APPEND, 8'd255);
    issue(lldq_pkg::FN_PREPEND, 8'd170);
    issue(lldq_pkg::FN_PREPEND, 8'd85);
    issue(lldq_pkg::FN_POP_TAIL, 8'd0);
    issue(lldq_pkg::FN_POP_HEAD, 8'd0);
    issue(lldq_pkg::FN_POP_TAIL, 8'd0);
    issue(lldq_pkg::FN_POP_HEAD, 8'd0);
    // reinsert the only node: self loop, then unwind to empty
    issue(lldq_pkg::FN_APPEND, 8'd5);
    issue(lldq_pkg::FN_APPEND, 8'd5);
    issue(lldq_pkg::FN_POP_TAIL, 8'd0);
    issue(lldq_pkg::FN_PREPEND, 8'd5);
    issue(lldq_pkg::FN_POP_HEAD, 8'd0);
    issue(lldq_pkg::FN_POP_HEAD, 8'd0);
    // reinsert the head at the tail so the tail walk runs off the list
    issue(lldq_pkg::FN_APPEND, 8'd1);
    issue(lldq_pkg::FN_APPEND, 8'd2);
    issue(lldq_pkg::FN_APPEND, 8'd3);
    issue(lldq_pkg::FN_APPEND, 8'd1);
    repeat (6) issue(lldq_pkg::FN_POP_TAIL, 8'd0);
    wait_drained();

    // well-formed episodes on short and medium lists
    while (items_sent < 450) begin
      target = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(9, 40);
      len = $urandom_range(15, 50);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (k = 0; k < len; k++) begin
        if (shadow.size() < target) begin
          if ($urandom_range(0, 99) < 65) insert_fresh();
          else pop_some(50);
        end else begin
          if ($urandom_range(0, 99) < 65) pop_some(50);
          else insert_fresh();
        end
      end
    end
    no_gaps = 1'b0;
    wait_drained();

    // fill every node, drain half, refill
    while (shadow.size() < lldq_pkg::NODES) begin
      if ($urandom_range(0, 99) < 95) insert_fresh();
      else pop_some(100);
    end
    while (shadow.size() > lldq_pkg::NODES / 2) pop_some(80);
    while (shadow.size() < lldq_pkg::NODES) insert_fresh();
    wait_drained();

    // full list: every insert is a reinsert and the count saturates
    repeat (8) begin
      issue($urandom_range(0, 1) ? lldq_pkg::FN_PREPEND : lldq_pkg::FN_APPEND,
            8'($urandom_range(0, 255)));
    end
    // noise on a corrupted list
    repeat (250) begin
      if ($urandom_range(0, 99) < 55)
        issue($urandom_range(0, 1) ? lldq_pkg::FN_POP_TAIL : lldq_pkg::FN_POP_HEAD,
              8'($urandom_range(0, 255)));
      else
        issue($urandom_range(0, 1) ? lldq_pkg::FN_PREPEND : lldq_pkg::FN_APPEND,
              8'($urandom_range(0, 255)));
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d items: %0d append, %0d prepend, %0d pop head, %0d pop tail",
             items_sent, ops_seen[lldq_pkg::FN_APPEND], ops_seen[lldq_pkg::FN_PREPEND],
             ops_seen[lldq_pkg::FN_POP_HEAD], ops_seen[lldq_pkg::FN_POP_TAIL]);
    $display("List grew to %0d nodes, then reinserts, saturation and broken links followed",
             max_fill);
    if (fail_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
